### design/base64_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_defines.svh
// Assertion macros shared by the base64 stream decoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold outside reset
`define B64D_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64D_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character decode table of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int OUT_COUNT_W     = 16;

	localparam logic [7:0] SYM_NUL   = 8'h00;
	localparam logic [7:0] SYM_PAD   = 8'h3D;  // '='
	localparam logic [7:0] SYM_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] SYM_SLASH = 8'h2F;  // '/'

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_PAD_ERR = 1'b1;

	// one queue entry: the results caused by one character
	typedef struct packed {
		logic                   has_data;
		logic                   has_end;
		logic [7:0]             data_byte;
		logic                   status;
		logic [OUT_COUNT_W-1:0] byte_count;
	} b64d_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} b64d_qstat_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} b64d_sextet_t;

	function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
		b64d_sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == SYM_PLUS) begin
			s.value = 6'd62;
		end else if (c == SYM_SLASH) begin
			s.value = 6'd63;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

endpackage

### design/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if
// Character channel: one base64 text character per beat.
// ----------------------------------------------------------------------------
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       final_char;

	modport source (output valid, output symbol, output final_char, input ready);
	modport sink   (input valid, input symbol, input final_char, output ready);
endinterface

### design/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if
// Result channel: a decoded byte or an end-of-message status per beat.
// ----------------------------------------------------------------------------
interface b64d_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  data_byte;
	logic        status;
	logic [15:0] byte_count;

	modport source (output valid, output result_kind, output data_byte,
		output status, output byte_count, input ready);
	modport sink   (input valid, input result_kind, input data_byte,
		input status, input byte_count, output ready);
endinterface

### design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, decodes them and keeps the per-message state.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64d_front #(
	parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	b64d_in_if.sink               text,
	input  b64d_pkg::b64d_qstat_t qstat,
	output logic                  push,
	output b64d_pkg::b64d_entry_t entry
);
	import b64d_pkg::*;

	logic [1:0]             phase_q, phase_d;
	logic [7:0]             partial_q, partial_d;
	logic                   stopped_q, stopped_d;
	logic                   pad_err_q, pad_err_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;

	logic         accept;
	logic         emit;
	logic [7:0]   byte_out;
	b64d_sextet_t sx;

	assign text.ready = !qstat.full;
	assign accept     = text.valid && text.ready;
	assign sx         = sextet_of(text.symbol);

	always_comb begin
		phase_d   = phase_q;
		partial_d = partial_q;
		stopped_d = stopped_q;
		pad_err_d = pad_err_q;
		count_d   = count_q;
		emit      = 1'b0;
		byte_out  = 8'd0;
		if (!stopped_q) begin
			if (text.symbol == SYM_NUL) begin
				stopped_d = 1'b1;
			end else if (text.symbol == SYM_PAD) begin
				stopped_d = 1'b1;
				if (phase_q < 2'd2) begin
					pad_err_d = 1'b1;
				end
			end else if (sx.valid) begin
				phase_d = phase_q + 2'd1;
				unique case (phase_q)
					2'd0: begin
						partial_d = {sx.value, 2'b00};
					end
					2'd1: begin
						emit      = 1'b1;
						byte_out  = partial_q | {6'd0, sx.value[5:4]};
						partial_d = {sx.value[3:0], 4'd0};
					end
					2'd2: begin
						emit      = 1'b1;
						byte_out  = partial_q | {4'd0, sx.value[5:2]};
						partial_d = {sx.value[1:0], 6'd0};
					end
					2'd3: begin
						emit     = 1'b1;
						byte_out = partial_q | {2'd0, sx.value};
					end
				endcase
				if (emit && count_q != {COUNT_WIDTH{1'b1}}) begin
					count_d = count_q + COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_comb begin
		entry.has_data   = emit;
		entry.has_end    = text.final_char;
		entry.data_byte  = byte_out;
		entry.status     = pad_err_d ? STATUS_PAD_ERR : STATUS_OK;
		entry.byte_count = OUT_COUNT_W'(count_d);
		push             = accept && (emit || text.final_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			partial_q <= 8'd0;
			stopped_q <= 1'b0;
			pad_err_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			if (text.final_char) begin
				phase_q   <= 2'd0;
				partial_q <= 8'd0;
				stopped_q <= 1'b0;
				pad_err_q <= 1'b0;
				count_q   <= '0;
			end else begin
				phase_q   <= phase_d;
				partial_q <= partial_d;
				stopped_q <= stopped_d;
				pad_err_q <= pad_err_d;
				count_q   <= count_d;
			end
		end
	end

	`B64D_ASSERT(a_final_clears, clk, arst_n,
		(accept && text.final_char) |=> (phase_q == 2'd0 && !stopped_q && !pad_err_q && count_q == '0),
		"front state not cleared after last character")
	`B64D_ASSERT(a_stop_sticks, clk, arst_n,
		(stopped_q && !(accept && text.final_char)) |=> stopped_q,
		"stop flag dropped inside a message")
	`B64D_ASSERT_NEVER(a_no_emit_stopped, clk, arst_n, push && stopped_q && entry.has_data,
		"data byte produced after stop")

endmodule

### design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short result queue between the decode front and the output sequencer.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64d_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64d_pkg::b64d_entry_t wr_entry,
	input  logic                  pop,
	output b64d_pkg::b64d_entry_t head,
	output b64d_pkg::b64d_qstat_t qstat
);
	import b64d_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	b64d_entry_t      entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.empty = (fill_q == '0);
	assign qstat.full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	`B64D_ASSERT_NEVER(a_push_full, clk, arst_n, push && qstat.full,
		"push into full queue")
	`B64D_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && qstat.empty,
		"pop from empty queue")
	`B64D_ASSERT_NEVER(a_fill_range, clk, arst_n, fill_q > CNT_W'(QUEUE_DEPTH),
		"queue fill beyond depth")

endmodule

### design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Output sequencer: sends each entry's data beat, then its end beat, where present.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64d_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64d_pkg::b64d_entry_t head,
	input  b64d_pkg::b64d_qstat_t qstat,
	output logic                  pop,
	b64d_out_if.source            decoded
);
	import b64d_pkg::*;

	logic data_done_q;
	logic show_data;
	logic beat;

	assign show_data = head.has_data && !data_done_q;
	assign beat      = decoded.valid && decoded.ready;
	// entry leaves once its last beat goes out
	assign pop       = beat && (!show_data || !head.has_end);

	always_comb begin
		decoded.valid       = !qstat.empty;
		decoded.result_kind = show_data ? KIND_DATA : KIND_END;
		decoded.data_byte   = show_data ? head.data_byte : 8'd0;
		decoded.status      = show_data ? STATUS_OK : head.status;
		decoded.byte_count  = show_data ? 16'd0 : head.byte_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_done_q <= 1'b0;
		end else if (pop) begin
			data_done_q <= 1'b0;
		end else if (beat && show_data) begin
			data_done_q <= 1'b1;
		end
	end

	`B64D_ASSERT(a_end_follows, clk, arst_n,
		(beat && show_data && head.has_end) |=> (decoded.valid && decoded.result_kind == KIND_END),
		"end beat missing after data beat")
	`B64D_ASSERT_NEVER(a_blank_entry, clk, arst_n, decoded.valid && !head.has_data && !head.has_end,
		"queue entry carries no result")
	`B64D_ASSERT_NEVER(a_done_no_end, clk, arst_n, data_done_q && !qstat.empty && !head.has_end,
		"data already sent for an entry without end")

endmodule

### design/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder with a decode front, result queue and sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   text    : one character a beat (symbol, final_char). NUL or '=' stops
//             decoding; later characters are ignored until the last one.
//   decoded : result beats. result_kind 0 carries a data byte, result_kind 1
//             closes the message with status (1 = misplaced padding) and
//             byte_count (saturating count, low 16 bits).
// A result is written into the queue when its character is taken and is
//   offered on decoded from there. Throughput: one character per cycle while
//   the queue is not full; the decode table and the partial-byte shift-or are combinational.
// A character carrying both a byte and the last mark gives two beats, data
//   first.
// A four-entry queue sits between front and sequencer; when decoded stalls
//   the queue fills and text.ready drops, nothing is lost.
// Reset clears the message state and empties the queue; text.ready is high
//   right after reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
	parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	b64d_in_if.sink    text,
	b64d_out_if.source decoded
);
	import b64d_pkg::*;

	b64d_entry_t wr_entry;
	b64d_entry_t head;
	b64d_qstat_t qstat;
	logic        push;
	logic        pop;

	b64d_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.qstat  (qstat),
		.push   (push),
		.entry  (wr_entry)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of base64_stream_decoder. Text characters are sent in random
// bursts while the decoded side stalls on its own pattern. A behavioral
// decoder in the bench predicts every data byte and end-of-message beat,
// and each decoded beat is checked field by field against it. Directed
// messages cover padding at each phase, NUL stops, skipped characters, the
// last mark on a byte-producing character and a long message whose byte
// count runs past eight bits.
// Random messages, mostly valid base64 plus noise, make up the rest.
// ----------------------------------------------------------------------------
module tb_top;
	import b64d_pkg::*;

	typedef struct {
		logic        kind;
		logic [7:0]  data;
		logic        status;
		logic [15:0] count;
	} decode_beat_t;

	localparam logic [15:0] COUNT_SAT = 16'hFFFF;

	logic clk;
	logic arst_n;

	b64d_in_if  text_ch ();
	b64d_out_if dec_ch ();

	base64_stream_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.decoded (dec_ch)
	);

	// decoder state as the bench sees it
	logic [1:0]   quantum_pos;
	logic [7:0]   byte_acc;
	logic         halted;
	logic         pad_misplaced;
	logic [15:0]  bytes_out;
	decode_beat_t awaited_decodes[$];

	int errors;
	int burst_left;
	bit gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	// -1 for characters outside the alphabet
	function automatic int alphabet_index(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'("A");
		if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
		if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
		if (c == SYM_PLUS) return 62;
		if (c == SYM_SLASH) return 63;
		return -1;
	endfunction

	function automatic logic [7:0] alphabet_char(input logic [5:0] v);
		if (v < 26) return 8'("A") + 8'(v);
		if (v < 52) return 8'("a") + 8'(v - 26);
		if (v < 62) return 8'("0") + 8'(v - 52);
		if (v == 62) return SYM_PLUS;
		return SYM_SLASH;
	endfunction

	task automatic clear_message();
		quantum_pos   = 2'd0;
		byte_acc      = 8'h00;
		halted        = 1'b0;
		pad_misplaced = 1'b0;
		bytes_out     = 16'd0;
	endtask

	task automatic decode_symbol(input logic [7:0] c, input logic fin);
		int           idx;
		logic [5:0]   sx;
		logic [7:0]   b;
		decode_beat_t r;
		idx = alphabet_index(c);
		sx  = 6'(idx);
		if (!halted) begin
			if (c == SYM_NUL) begin
				halted = 1'b1;
			end else if (c == SYM_PAD) begin
				halted = 1'b1;
				if (quantum_pos < 2'd2) pad_misplaced = 1'b1;
			end else if (idx >= 0) begin
				b = 8'h00;
				case (quantum_pos)
					2'd0: byte_acc = {sx, 2'b00};
					2'd1: begin
						b        = byte_acc | {6'd0, sx[5:4]};
						byte_acc = {sx[3:0], 4'h0};
					end
					2'd2: begin
						b        = byte_acc | {4'd0, sx[5:2]};
						byte_acc = {sx[1:0], 6'd0};
					end
					default: b = byte_acc | {2'd0, sx};
				endcase
				if (quantum_pos != 2'd0) begin
					if (bytes_out != COUNT_SAT) bytes_out++;
					r = '{KIND_DATA, b, STATUS_OK, 16'd0};
					awaited_decodes.push_back(r);
				end
				quantum_pos = quantum_pos + 2'd1;
			end
		end
		if (fin) begin
			r = '{KIND_END, 8'h00, pad_misplaced ? STATUS_PAD_ERR : STATUS_OK, bytes_out};
			awaited_decodes.push_back(r);
			clear_message();
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic fin);
		if (gaps_on && burst_left == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		text_ch.valid      <= 1'b1;
		text_ch.symbol     <= c;
		text_ch.final_char <= fin;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		decode_symbol(c, fin);
		if (burst_left > 0) burst_left--;
	endtask

	task automatic send_text(input string s, input bit fin_last);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], fin_last && i == s.len() - 1);
		end
	endtask

	task automatic test_basic_quantum();
		send_text("TWFu", 1'b1);
	endtask

	task automatic test_padding_phases();
		send_text("=", 1'b1);
		send_text("Q=A", 1'b1);
		send_text("QU==", 1'b1);
		send_text("QUJ=", 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	task automatic test_skip_and_nul();
		send_char(8'hFF, 1'b0);
		send_char(8'h80, 1'b0);
		send_text(" /+", 1'b0);
		send_char(SYM_NUL, 1'b0);
		send_text("z", 1'b1);
	endtask

	// long message of all-ones bytes closed by a zero byte, the count runs past eight bits
	task automatic test_long_message();
		gaps_on = 1'b0;
		repeat (400) send_char(SYM_SLASH, 1'b0);
		send_text("AB", 1'b1);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_messages();
		logic [7:0]  chars[$];
		logic [7:0]  raw[$];
		logic [23:0] w;
		int          sent;
		int          n;
		int          nchars;
		int          style;
		sent = 0;
		while (sent < 800) begin
			chars.delete();
			raw.delete();
			gaps_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 7) begin
				n = $urandom_range(0, 12);
				repeat (n) raw.push_back(8'($urandom));
				for (int i = 0; i < n; i += 3) begin
					w = {raw[i], (i + 1 < n) ? raw[i + 1] : 8'h00,
						(i + 2 < n) ? raw[i + 2] : 8'h00};
					nchars = (n - i >= 3) ? 4 : n - i + 1;
					for (int k = 0; k < nchars; k++) begin
						if ($urandom_range(0, 15) == 0) chars.push_back(8'($urandom));
						chars.push_back(alphabet_char(w[23 - 6 * k -: 6]));
					end
				end
				style = $urandom_range(0, 3);
				if (style == 1 || style == 3) begin
					repeat ((3 - n % 3) % 3) chars.push_back(SYM_PAD);
				end
				if (style == 2) chars.push_back(SYM_NUL);
				if (style == 3) repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 1) == 0) begin
						chars.push_back(8'($urandom));
					end else begin
						chars.push_back(alphabet_char(6'($urandom)));
					end
				end
			end
			if (chars.size() == 0) chars.push_back(8'($urandom));
			foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
			sent += chars.size();
		end
	endtask

	// receiver: ready follows a rotating pattern, reloaded at random whenever pat_age wraps
	initial begin
		logic [15:0]  ready_pat;
		int           pat_age;
		decode_beat_t exp_beat;
		ready_pat = 16'hFFFF;
		pat_age   = 0;
		dec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dec_ch.valid && dec_ch.ready) begin
				if (awaited_decodes.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat kind=%0d data=%02h status=%0d count=%0d",
						$time, dec_ch.result_kind, dec_ch.data_byte, dec_ch.status,
						dec_ch.byte_count);
				end else begin
					exp_beat = awaited_decodes.pop_front();
					if (dec_ch.result_kind !== exp_beat.kind
						|| dec_ch.data_byte !== exp_beat.data
						|| dec_ch.status !== exp_beat.status
						|| dec_ch.byte_count !== exp_beat.count) begin
						errors++;
						$display("%0t: mismatch expected kind=%0d data=%02h status=%0d count=%0d",
							$time, exp_beat.kind, exp_beat.data, exp_beat.status,
							exp_beat.count);
						$display("%0t:          actual   kind=%0d data=%02h status=%0d count=%0d",
							$time, dec_ch.result_kind, dec_ch.data_byte, dec_ch.status,
							dec_ch.byte_count);
					end
				end
			end
			pat_age++;
			if (pat_age == 32) begin
				pat_age = 0;
				case ($urandom_range(0, 3))
					0: ready_pat = 16'hFFFF;
					1: ready_pat = 16'($urandom);
					2: ready_pat = 16'($urandom) | 16'($urandom);
					default: ready_pat = 16'($urandom) & 16'($urandom);
				endcase
			end
			dec_ch.ready <= ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[15:1]};
		end
	end

	initial begin
		errors     = 0;
		burst_left = 0;
		gaps_on    = 1'b1;
		clear_message();
		arst_n             = 1'b0;
		text_ch.valid      <= 1'b0;
		text_ch.symbol     <= 8'h00;
		text_ch.final_char <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_quantum();
		test_padding_phases();
		test_skip_and_nul();
		test_long_message();
		test_random_messages();

		text_ch.valid <= 1'b0;
		while (awaited_decodes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
